[hw/rtl/adcsm_pkg.sv]
// adcsm_pkg: widths, reset values and register indexes for the adc smoother
// no dependencies; used by the interfaces and the smoother top level
package adcsm_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int WIN_LEN     = 16;
    localparam int SLOT_BITS   = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
    localparam int CNT_BITS    = $clog2(WIN_LEN + 1);
    localparam int SUM_BITS    = SAMPLE_BITS + $clog2(WIN_LEN);
    localparam int FRAC_BITS   = 8;
    localparam int SMOOTH_BITS = SAMPLE_BITS + FRAC_BITS;
    localparam int ALPHA_BITS  = 16;
    localparam int LEVEL_BITS  = 7;
    localparam int LEVEL_MAX   = (1 << LEVEL_BITS) - 1;

    // scaling: num = diff * 2 * LEVEL_MAX + span, den = 2 * span
    localparam int NUM_BITS  = SMOOTH_BITS + LEVEL_BITS + 2;
    localparam int DEN_BITS  = SMOOTH_BITS + 1;
    localparam int REM_BITS  = DEN_BITS;
    localparam int DVD_BITS  = (SUM_BITS > LEVEL_BITS) ? SUM_BITS : LEVEL_BITS;
    localparam int STEP_BITS = $clog2(DVD_BITS + 1);

    localparam int PROD_BITS = ALPHA_BITS + SMOOTH_BITS;
    localparam int ACC_BITS  = ALPHA_BITS + SMOOTH_BITS + 2;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = ALPHA_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ALPHA  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CV_MIN = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CV_MAX = 2'd2;

    localparam logic [ALPHA_BITS-1:0]  ALPHA_RESET  = ALPHA_BITS'(6554);
    localparam logic [SAMPLE_BITS-1:0] CV_MIN_RESET = '0;
    localparam logic [SAMPLE_BITS-1:0] CV_MAX_RESET = '1;

endpackage

[hw/rtl/adcsm_sample_if.sv]
// adcsm_sample_if: valid/ready channel carrying one raw converter sample
// depends on adcsm_pkg
interface adcsm_sample_if import adcsm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

[hw/rtl/adcsm_result_if.sv]
// adcsm_result_if: valid/ready channel carrying one smoother result
// depends on adcsm_pkg
interface adcsm_result_if import adcsm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] window_mean;
    logic [SMOOTH_BITS-1:0] smoothed;
    logic [LEVEL_BITS-1:0]  scaled_level;

    modport source (output valid, output window_mean, output smoothed,
                    output scaled_level, input ready);
    modport sink   (input valid, input window_mean, input smoothed,
                    input scaled_level, output ready);
endinterface

[hw/rtl/adcsm_ram.sv]
// adcsm_ram: generic single-write, single-read ram with registered read data
// no dependencies
module adcsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/adc_moving_average_iir_smoother.sv]
// adc_moving_average_iir_smoother: moving average, single-pole iir, 0..127 scaling
// depends on adcsm_pkg, adcsm_sample_if, adcsm_result_if, adcsm_ram
//
// Usage
//   i_sample_ch takes one 12-bit converter sample per transfer; o_result_ch
//   gives one result per sample: the truncated window mean, the iir state
//   (unsigned Q12.8) and the level scaled from [cv_min, cv_max] onto 0..127.
//   alpha, cv_min and cv_max are written through i_cfg_we/i_cfg_idx/i_cfg_data;
//   the user writes them only while no sample is in flight (not enforced here).
// Timing
//   The window lives in a ram; the old entry is read the cycle after the
//   transfer and overwritten in the same cycle the running sum is updated.
//   One shared restoring divider produces the mean (16 steps) and the scaled
//   level (7 steps, skipped when the level clamps or is zero). A new sample is
//   taken only once the last sample's result is in the output register, so
//   the block handles one sample at a time.
// Reset and stall
//   i_rst_n (synchronous, active low) empties the window, clears the iir state
//   and restores the register defaults. The result is held in an output
//   register: a stalled receiver does not block the next input transfer, but
//   that sample's result waits in the last step until the register is free.
module adc_moving_average_iir_smoother import adcsm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    adcsm_sample_if.sink             i_sample_ch,
    adcsm_result_if.source           o_result_ch
);
    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_DIV_MEAN,
        S_MUL_NEW,
        S_MUL_OLD,
        S_SCL_NUM,
        S_SCL_CHK,
        S_DIV_SCL,
        S_DONE
    } t_state;

    t_state r_state_q;

    logic [ALPHA_BITS-1:0]  r_alpha;
    logic [SAMPLE_BITS-1:0] r_cv_min;
    logic [SAMPLE_BITS-1:0] r_cv_max;

    logic [SAMPLE_BITS-1:0] r_sample;
    logic [SUM_BITS-1:0]    r_sum;
    logic [CNT_BITS-1:0]    r_fill;
    logic [SLOT_BITS-1:0]   r_slot;
    logic [SMOOTH_BITS-1:0] r_iir;
    logic [SAMPLE_BITS-1:0] r_mean;
    logic [PROD_BITS-1:0]   r_prod;
    logic [NUM_BITS-1:0]    r_num;
    logic [DEN_BITS-1:0]    r_den;
    logic                   r_scl_zero;

    // shared divider
    logic [REM_BITS-1:0]  r_rem;
    logic [DVD_BITS-1:0]  r_dvd;
    logic [DEN_BITS-1:0]  r_dvs;
    logic [DVD_BITS-1:0]  r_quo;
    logic [STEP_BITS-1:0] r_step;

    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_mean;
    logic [SMOOTH_BITS-1:0] r_out_smooth;
    logic [LEVEL_BITS-1:0]  r_out_level;

    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic                   ram_we;

    logic                   in_xfer;
    logic                   out_xfer;
    logic [SUM_BITS-1:0]    n_sum;
    logic [CNT_BITS-1:0]    n_fill;
    logic [REM_BITS:0]      n_trial;
    logic                   n_ge;
    logic [REM_BITS-1:0]    n_rem;
    logic [DVD_BITS-1:0]    n_quo;
    logic [ALPHA_BITS:0]    n_keep;
    logic [ACC_BITS-1:0]    n_keep_prod;
    logic [ACC_BITS-1:0]    n_acc;
    logic [SMOOTH_BITS-1:0] n_lo;
    logic [SMOOTH_BITS-1:0] n_span;
    logic [SMOOTH_BITS-1:0] n_diff;
    logic [NUM_BITS-1:0]    n_num;

    adcsm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WIN_LEN)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (r_sample),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    assign i_sample_ch.ready = (r_state_q == S_IDLE);
    assign in_xfer  = i_sample_ch.valid && (r_state_q == S_IDLE);
    assign out_xfer = r_out_valid && o_result_ch.ready;
    assign ram_we   = (r_state_q == S_READ);

    assign o_result_ch.valid        = r_out_valid;
    assign o_result_ch.window_mean  = r_out_mean;
    assign o_result_ch.smoothed     = r_out_smooth;
    assign o_result_ch.scaled_level = r_out_level;

    always_comb begin
        // window sum update; the old entry only counts once the window is full
        if (r_fill < CNT_BITS'(WIN_LEN)) begin
            n_sum  = r_sum + SUM_BITS'(r_sample);
            n_fill = r_fill + CNT_BITS'(1);
        end else begin
            n_sum  = r_sum - SUM_BITS'(ram_rdata) + SUM_BITS'(r_sample);
            n_fill = r_fill;
        end

        // one restoring division step
        n_trial = {r_rem, r_dvd[DVD_BITS-1]};
        n_ge    = (n_trial >= (REM_BITS+1)'(r_dvs));
        n_rem   = n_ge ? REM_BITS'(n_trial - (REM_BITS+1)'(r_dvs)) : REM_BITS'(n_trial);
        n_quo   = {r_quo[DVD_BITS-2:0], n_ge};

        // iir: old-state weight and rounded sum
        n_keep      = (ALPHA_BITS+1)'(1 << ALPHA_BITS) - (ALPHA_BITS+1)'(r_alpha);
        n_keep_prod = ACC_BITS'(n_keep) * ACC_BITS'(r_iir);
        n_acc       = ACC_BITS'(r_prod) + n_keep_prod
                    + ACC_BITS'(1 << (ALPHA_BITS - 1));

        // scaling numerator
        n_lo   = {r_cv_min, FRAC_BITS'(0)};
        n_span = {r_cv_max - r_cv_min, FRAC_BITS'(0)};
        n_diff = r_iir - n_lo;
        n_num  = NUM_BITS'(n_diff) * NUM_BITS'(2 * LEVEL_MAX) + NUM_BITS'(n_span);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_q   <= S_IDLE;
            r_alpha     <= ALPHA_RESET;
            r_cv_min    <= CV_MIN_RESET;
            r_cv_max    <= CV_MAX_RESET;
            r_sum       <= '0;
            r_fill      <= '0;
            r_slot      <= '0;
            r_iir       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ALPHA:  r_alpha  <= i_cfg_data[ALPHA_BITS-1:0];
                    CFG_CV_MIN: r_cv_min <= i_cfg_data[SAMPLE_BITS-1:0];
                    CFG_CV_MAX: r_cv_max <= i_cfg_data[SAMPLE_BITS-1:0];
                    default: ;
                endcase
            end

            // in the last step the waiting result is replaced there
            if (out_xfer && (r_state_q != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state_q)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_sample  <= i_sample_ch.sample;
                        r_state_q <= S_READ;
                    end
                end
                S_READ: begin
                    r_sum  <= n_sum;
                    r_fill <= n_fill;
                    if (r_slot == SLOT_BITS'(WIN_LEN - 1)) begin
                        r_slot <= '0;
                    end else begin
                        r_slot <= r_slot + SLOT_BITS'(1);
                    end
                    r_rem     <= '0;
                    r_dvd     <= DVD_BITS'(n_sum);
                    r_dvs     <= DEN_BITS'(n_fill);
                    r_quo     <= '0;
                    r_step    <= STEP_BITS'(SUM_BITS);
                    r_state_q <= S_DIV_MEAN;
                end
                S_DIV_MEAN: begin
                    r_rem  <= n_rem;
                    r_dvd  <= {r_dvd[DVD_BITS-2:0], 1'b0};
                    r_quo  <= n_quo;
                    r_step <= r_step - STEP_BITS'(1);
                    if (r_step == STEP_BITS'(1)) begin
                        r_mean    <= n_quo[SAMPLE_BITS-1:0];
                        r_state_q <= S_MUL_NEW;
                    end
                end
                S_MUL_NEW: begin
                    r_prod    <= PROD_BITS'(r_alpha) * PROD_BITS'({r_mean, FRAC_BITS'(0)});
                    r_state_q <= S_MUL_OLD;
                end
                S_MUL_OLD: begin
                    r_iir     <= n_acc[ALPHA_BITS +: SMOOTH_BITS];
                    r_state_q <= S_SCL_NUM;
                end
                S_SCL_NUM: begin
                    r_scl_zero <= (r_cv_max <= r_cv_min) || (r_iir <= n_lo);
                    r_num      <= n_num;
                    r_den      <= {n_span, 1'b0};
                    r_state_q  <= S_SCL_CHK;
                end
                S_SCL_CHK: begin
                    if (r_scl_zero) begin
                        r_quo     <= '0;
                        r_state_q <= S_DONE;
                    end else if (r_num >= NUM_BITS'({r_den, LEVEL_BITS'(0)})) begin
                        // quotient would pass the top level: clamp
                        r_quo     <= DVD_BITS'(LEVEL_MAX);
                        r_state_q <= S_DONE;
                    end else begin
                        r_rem     <= r_num[LEVEL_BITS +: REM_BITS];
                        r_dvd     <= {r_num[LEVEL_BITS-1:0], (DVD_BITS-LEVEL_BITS)'(0)};
                        r_dvs     <= r_den;
                        r_quo     <= '0;
                        r_step    <= STEP_BITS'(LEVEL_BITS);
                        r_state_q <= S_DIV_SCL;
                    end
                end
                S_DIV_SCL: begin
                    r_rem  <= n_rem;
                    r_dvd  <= {r_dvd[DVD_BITS-2:0], 1'b0};
                    r_quo  <= n_quo;
                    r_step <= r_step - STEP_BITS'(1);
                    if (r_step == STEP_BITS'(1)) begin
                        r_state_q <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_result_ch.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_mean   <= r_mean;
                        r_out_smooth <= r_iir;
                        r_out_level  <= r_quo[LEVEL_BITS-1:0];
                        r_state_q    <= S_IDLE;
                    end
                end
                default: r_state_q <= S_IDLE;
            endcase
        end
    end
endmodule
